// ----- src/srfsa_pkg.sv -----
// Package: shared types, codes and float constants for the row scatter accumulator.
`default_nettype none
package srfsa_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ACCUM = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  lane;
        logic [17:0] row;
        logic [31:0] product;
    } cmd_t;

    typedef struct packed {
        logic [31:0] sum_low;
        logic [31:0] sum_high;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_ADD1,
        ST_ADD2,
        ST_ADD3,
        ST_OUT
    } state_t;

    localparam int ROW_COUNT_W = 21;
    localparam logic [31:0] QNAN = 32'h7FC00000;

endpackage
`default_nettype wire

// ----- src/sparse_row_float_scatter_accumulator.sv -----
// Top level: banked float scratchpad with clear, accumulate and readout commands.
//
//  channel   | ports                           | handshake
//  command   | start, busy, cmd                | taken when start && !busy
//  result    | res_valid, res                  | one-cycle strobe, no back-pressure
//  config    | row_count_we, row_count_wdata   | written when row_count_we
//
// Accumulate: memory read, three adder stages, write back; padding and ignored
// items leave the block idle. Readout: memory read, then the result.
// Clear: one entry per cycle, lanes walked inside each word index, over
// min(ceil(M/(16*CHANNELS)),depth) word indices.
// Reset clears control only; the banks are undefined until a clear transfer.
// The result is never stalled; busy alone paces the command side.
`default_nettype none
module sparse_row_float_scatter_accumulator #(
    parameter int BANK_DEPTH = 4096,
    parameter int LANES      = 8,
    parameter int CHANNELS   = 24
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire srfsa_pkg::cmd_t cmd,
    output logic                 res_valid,
    output srfsa_pkg::res_t      res,
    input  wire                  row_count_we,
    input  wire [srfsa_pkg::ROW_COUNT_W-1:0] row_count_wdata
);

    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW = AW + 1;
    localparam int CLR_DIV = 16 * CHANNELS;
    localparam int OUT_DIV = 2 * CHANNELS;

    // Reciprocal constants for the length divisions (exact over NUM_W-bit numerators)
    localparam int NUM_W  = srfsa_pkg::ROW_COUNT_W + 1;
    localparam int PRD_W  = 2 * NUM_W + 1;
    localparam int CLR_SH = NUM_W + $clog2(CLR_DIV);
    localparam int OUT_SH = NUM_W + $clog2(OUT_DIV);
    localparam logic [NUM_W:0] CLR_RCP = (NUM_W+1)'(((64'd1 << CLR_SH) + 64'(CLR_DIV)
                                                     - 64'd1) / 64'(CLR_DIV));
    localparam logic [NUM_W:0] OUT_RCP = (NUM_W+1)'(((64'd1 << OUT_SH) + 64'(OUT_DIV)
                                                     - 64'd1) / 64'(OUT_DIV));

    // Memory: one array, lanes side by side in the address
    logic [63:0] mem [LANES*BANK_DEPTH];
    logic [63:0] rd_data;

    srfsa_pkg::state_t state_reg, state_next;
    logic [srfsa_pkg::ROW_COUNT_W-1:0] row_count_reg;
    logic [15:0] rcount_reg, rcount_next;
    logic [CW-1:0] clr_words_reg, clr_idx_reg;
    logic [AW+LW-1:0] addr_reg;
    logic [LW-1:0] clr_lane_reg;
    logic half_reg, last_reg;
    logic [31:0] prod_reg;
    logic [20:0] tot_reg;

    // Lengths derived from the register (ceiling division by reciprocal)
    logic [20:0] clr_words_full, total_words;
    logic [NUM_W-1:0] clr_num, out_num;
    logic [PRD_W-1:0] clr_prod, out_prod;
    assign clr_num  = NUM_W'(row_count_reg) + NUM_W'(CLR_DIV - 1);
    assign out_num  = NUM_W'(row_count_reg) + NUM_W'(OUT_DIV - 1);
    assign clr_prod = PRD_W'(clr_num) * PRD_W'(CLR_RCP);
    assign out_prod = PRD_W'(out_num) * PRD_W'(OUT_RCP);
    assign clr_words_full = 21'(clr_prod >> CLR_SH);
    assign total_words    = 21'(out_prod >> OUT_SH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_count_reg <= '0;
        else if (row_count_we)
            row_count_reg <= row_count_wdata;
    end

    // Float adder: stage 1 align, stage 2 add, stage 3 normalise and round
    logic [31:0] opa, opb;
    assign opa = half_reg ? rd_data[63:32] : rd_data[31:0];
    assign opb = prod_reg;

    logic        s1_special;
    logic [31:0] s1_special_val;
    logic        s1_sa, s1_sb;
    logic [7:0]  s1_exp;
    logic [27:0] s1_ma, s1_mb;
    logic [63:0] s1_word;

    always_ff @(posedge clk)
    begin
        logic [7:0]  ea, eb, ebig;
        logic [23:0] ma, mb;
        logic        na, nb, ia, ib, swap;
        logic [26:0] big, sml, shf;
        logic [7:0]  d;
        logic        stk;
        ea = (opa[30:23] == 8'd0) ? 8'd1 : opa[30:23];
        eb = (opb[30:23] == 8'd0) ? 8'd1 : opb[30:23];
        ma = {opa[30:23] != 8'd0, opa[22:0]};
        mb = {opb[30:23] != 8'd0, opb[22:0]};
        na = (opa[30:23] == 8'hFF) && (opa[22:0] != 0);
        nb = (opb[30:23] == 8'hFF) && (opb[22:0] != 0);
        ia = (opa[30:23] == 8'hFF) && (opa[22:0] == 0);
        ib = (opb[30:23] == 8'hFF) && (opb[22:0] == 0);
        swap = {eb, mb} > {ea, ma};
        big  = swap ? {mb, 3'b0} : {ma, 3'b0};
        sml  = swap ? {ma, 3'b0} : {mb, 3'b0};
        ebig = swap ? eb : ea;
        d    = swap ? (eb - ea) : (ea - eb);
        if (d > 8'd26)
        begin
            shf = '0;
            stk = sml != 0;
        end
        else
        begin
            shf = sml >> d;
            stk = (sml & ((27'd1 << d) - 27'd1)) != 0;
        end
        s1_special <= na || nb || ia || ib;
        if (na || nb || (ia && ib && (opa[31] != opb[31])))
            s1_special_val <= srfsa_pkg::QNAN;
        else if (ia)
            s1_special_val <= opa;
        else
            s1_special_val <= opb;
        s1_sa  <= swap ? opb[31] : opa[31];
        s1_sb  <= swap ? opa[31] : opb[31];
        s1_exp <= ebig;
        s1_ma  <= {1'b0, big};
        s1_mb  <= {1'b0, shf[26:1], shf[0] | stk};
        s1_word <= rd_data;
    end

    logic        s2_special, s2_sign, s2_zero_sub, s2_bothneg;
    logic [31:0] s2_special_val;
    logic [7:0]  s2_exp;
    logic [27:0] s2_m;
    logic [63:0] s2_word;

    always_ff @(posedge clk)
    begin
        s2_special     <= s1_special;
        s2_special_val <= s1_special_val;
        s2_exp         <= s1_exp;
        s2_sign        <= s1_sa;
        s2_bothneg     <= s1_sa && s1_sb;
        s2_zero_sub    <= s1_sa != s1_sb;
        s2_m           <= (s1_sa == s1_sb) ? (s1_ma + s1_mb) : (s1_ma - s1_mb);
        s2_word        <= s1_word;
    end

    logic [31:0] s3_sum;
    always_ff @(posedge clk)
    begin
        logic [27:0] m;
        logic [4:0]  lz;
        logic [9:0]  e;
        logic [27:0] n;
        logic [24:0] r;
        logic        g, st, found;
        m = s2_m;
        lz = 5'd0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                found = 1'b1;
                lz = 5'(27 - i);
            end
        end
        // bit 26 is the implicit one position
        if (s2_special)
            s3_sum <= s2_special_val;
        else if (m == 0)
            s3_sum <= {s2_zero_sub ? 1'b0 : s2_bothneg, 31'd0};
        else
        begin
            if (lz == 5'd0)
            begin
                n = {1'b0, m[27:2], m[1] | m[0]};
                e = {2'b0, s2_exp} + 10'd1;
            end
            else if ({5'd0, lz} - 10'd1 < {2'b0, s2_exp})
            begin
                n = m << (lz - 5'd1);
                e = {2'b0, s2_exp} - ({5'd0, lz} - 10'd1);
            end
            else
            begin
                n = m << (s2_exp - 8'd1);
                e = 10'd0;
            end
            if (e != 0 && !n[26])
                e = 10'd0;
            g  = n[2];
            st = n[1] | n[0];
            r  = {1'b0, n[26:3]} + {24'd0, g && (st || n[3])};
            if (r[24])
            begin
                r = r >> 1;
                e = e + 10'd1;
            end
            else if (e == 0 && r[23])
                e = 10'd1;
            if (e >= 10'd255)
                s3_sum <= {s2_sign, 8'hFF, 23'd0};
            else
                s3_sum <= {s2_sign, e[7:0], r[22:0]};
        end
    end

    logic [63:0] s3_word;
    always_ff @(posedge clk)
        s3_word <= s2_word;

    // Memory port: read one, write one per cycle
    logic            mem_we;
    logic [AW+LW-1:0] mem_waddr, mem_raddr;
    logic [63:0]     mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data <= mem[mem_raddr];
    end

    logic [AW+LW-1:0] cmd_addr;
    logic [AW-1:0]    acc_word;
    logic [AW-1:0]    rd_word;
    logic [LW-1:0]    rd_lane;
    logic [15:0]      rc_eff;
    assign acc_word = AW'(32'(cmd.row[16:1]) % BANK_DEPTH);
    assign rc_eff   = (21'(rcount_reg) >= total_words) ? 16'd0 : rcount_reg;
    assign rd_lane  = LW'(32'(rc_eff) % LANES);
    assign rd_word  = AW'((32'(rc_eff) / LANES) % BANK_DEPTH);

    always_comb
    begin
        state_next  = state_reg;
        rcount_next = rcount_reg;
        busy        = state_reg != srfsa_pkg::ST_IDLE;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = half_reg ? {s3_sum, s3_word[31:0]} : {s3_word[63:32], s3_sum};
        mem_raddr   = {LW'(cmd.lane), acc_word};
        cmd_addr    = {LW'(cmd.lane), acc_word};
        res_valid   = 1'b0;
        unique case (state_reg)
            srfsa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    priority if (cmd.func == srfsa_pkg::FUNC_CLEAR)
                    begin
                        state_next  = srfsa_pkg::ST_CLEAR;
                        rcount_next = '0;
                    end
                    else if (cmd.func == srfsa_pkg::FUNC_ACCUM)
                    begin
                        if (!cmd.row[17] && 32'(cmd.lane) < LANES)
                            state_next = srfsa_pkg::ST_RD;
                    end
                    else if (cmd.func == srfsa_pkg::FUNC_READ)
                    begin
                        if (total_words != 0)
                        begin
                            mem_raddr  = {rd_lane, rd_word};
                            state_next = srfsa_pkg::ST_OUT;
                            rcount_next = (21'(rc_eff) == total_words - 21'd1) ?
                                          16'd0 : rc_eff + 16'd1;
                        end
                    end
                    else
                    begin
                        // unused code: nothing to do
                        state_next = srfsa_pkg::ST_IDLE;
                    end
                end
            end
            srfsa_pkg::ST_CLEAR:
            begin
                mem_we    = clr_idx_reg < clr_words_reg;
                mem_waddr = {clr_lane_reg, clr_idx_reg[AW-1:0]};
                mem_wdata = '0;
                if (!mem_we)
                    state_next = srfsa_pkg::ST_IDLE;
            end
            srfsa_pkg::ST_RD:   state_next = srfsa_pkg::ST_ADD1;
            srfsa_pkg::ST_ADD1: state_next = srfsa_pkg::ST_ADD2;
            srfsa_pkg::ST_ADD2: state_next = srfsa_pkg::ST_ADD3;
            srfsa_pkg::ST_ADD3:
            begin
                mem_we     = 1'b1;
                state_next = srfsa_pkg::ST_IDLE;
            end
            srfsa_pkg::ST_OUT:
            begin
                res_valid  = 1'b1;
                state_next = srfsa_pkg::ST_IDLE;
            end
            default: state_next = srfsa_pkg::ST_IDLE;
        endcase
    end

    assign res.sum_low  = rd_data[31:0];
    assign res.sum_high = rd_data[63:32];
    assign res.last     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= srfsa_pkg::ST_IDLE;
            rcount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rcount_reg <= rcount_next;
        end
    end

    // Command capture on start, and clear sweep: lanes walked inside each word index
    always_ff @(posedge clk)
    begin
        if (state_reg == srfsa_pkg::ST_IDLE && start)
        begin
            addr_reg      <= cmd_addr;
            half_reg      <= cmd.row[0];
            prod_reg      <= cmd.product;
            last_reg      <= 21'(rc_eff) == total_words - 21'd1;
            tot_reg       <= total_words;
            clr_idx_reg   <= '0;
            clr_lane_reg  <= '0;
            clr_words_reg <= (clr_words_full > 21'(BANK_DEPTH)) ? CW'(BANK_DEPTH) :
                             CW'(clr_words_full);
        end
        else if (state_reg == srfsa_pkg::ST_CLEAR)
        begin
            if (32'(clr_lane_reg) == LANES - 1)
            begin
                clr_lane_reg <= '0;
                clr_idx_reg  <= clr_idx_reg + CW'(1);
            end
            else
                clr_lane_reg <= clr_lane_reg + LW'(1);
        end
    end

    // Checks
    a_res_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> state_reg == srfsa_pkg::ST_OUT) else $error("stray result");
    a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(start) && !$past(busy)) else $error("result without read");
    a_wb_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srfsa_pkg::ST_ADD3 |-> $past(state_reg, 3) == srfsa_pkg::ST_RD)
        else $error("write back out of order");
    a_last_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |-> rcount_reg == 16'd0) else $error("count not wrapped");
    a_tot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> tot_reg != 21'd0) else $error("empty readout produced word");

endmodule
`default_nettype wire
